// File: src/fac_pkg.sv
`default_nettype none
package fac_pkg;

  localparam int TIME_BITS = 32;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FALL_THRESHOLD  = 3'd0,
    CFG_DETECT_WINDOW   = 3'd1,
    CFG_ALARM_DURATION  = 3'd2,
    CFG_FLASH_HALF      = 3'd3,
    CFG_CANCEL_HOLD     = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SCREEN_OK     = 2'd0,
    SCREEN_FALL   = 2'd1,
    SCREEN_CANCEL = 2'd2
  } screen_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_FALL         = 3'd1,
    EV_CANCELLED    = 3'd2,
    EV_EXPIRED      = 3'd3,
    EV_CANCEL_ENDED = 3'd4
  } event_t;

  localparam logic [14:0] THRESHOLD_RESET = 15'd4096;
  localparam logic [15:0] WINDOW_RESET    = 16'd500;
  localparam logic [15:0] DURATION_RESET  = 16'd10000;
  localparam logic [15:0] HALF_RESET      = 16'd500;
  localparam logic [15:0] HOLD_RESET      = 16'd5000;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [15:0] accel_sample;
    logic               button_pressed;
  } in_item_t;

  typedef struct packed {
    logic       led_lit;
    logic [1:0] display_mode;
    logic [2:0] event_code;
  } out_item_t;

  typedef struct packed {
    logic [14:0] fall_threshold;
    logic [15:0] detect_window_ms;
    logic [15:0] alarm_duration_ms;
    logic [15:0] flash_half_period_ms;
    logic [15:0] cancel_hold_ms;
  } cfg_t;

endpackage
`default_nettype wire

// File: src/fac_cfg_regs.sv
`default_nettype none
module fac_cfg_regs
  import fac_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                           cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fall_threshold       <= THRESHOLD_RESET;
      regs.detect_window_ms     <= WINDOW_RESET;
      regs.alarm_duration_ms    <= DURATION_RESET;
      regs.flash_half_period_ms <= HALF_RESET;
      regs.cancel_hold_ms       <= HOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FALL_THRESHOLD: regs.fall_threshold       <= cfg_data[14:0];
        CFG_DETECT_WINDOW:  regs.detect_window_ms     <= cfg_data;
        CFG_ALARM_DURATION: regs.alarm_duration_ms    <= cfg_data;
        CFG_FLASH_HALF:     regs.flash_half_period_ms <= cfg_data;
        CFG_CANCEL_HOLD:    regs.cancel_hold_ms       <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign cfg = regs;

endmodule
`default_nettype wire

// File: src/fac_core.sv
`default_nettype none
module fac_core
  import fac_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step,
  input  in_item_t      item,
  input  cfg_t          cfg,
  output out_item_t     result
);

  logic    alarm_active, alarm_active_next;
  logic    cancel_pending, cancel_pending_next;
  logic    cancel_shown, cancel_shown_next;
  logic    flash_level, flash_level_next;
  time_t   window_start_ms, window_start_ms_next;
  time_t   flash_start_ms, flash_start_ms_next;
  screen_t screen_state, screen_state_next;

  time_t       t;
  time_t       since_window;
  time_t       since_flash;
  logic [14:0] mag;

  assign t            = TIME_BITS'(item.now_ms);
  assign since_window = t - window_start_ms;
  assign since_flash  = t - flash_start_ms;

  // |accel| with the most negative code clipped to full scale
  always_comb begin
    if (!item.accel_sample[15]) begin
      mag = item.accel_sample[14:0];
    end else if (item.accel_sample == 16'sh8000) begin
      mag = 15'h7fff;
    end else begin
      mag = 15'(-item.accel_sample);
    end
  end

  always_comb begin
    event_t ev;
    logic   led;
    alarm_active_next    = alarm_active;
    cancel_pending_next  = cancel_pending;
    cancel_shown_next    = cancel_shown;
    flash_level_next     = flash_level;
    window_start_ms_next = window_start_ms;
    flash_start_ms_next  = flash_start_ms;
    screen_state_next    = screen_state;
    ev  = EV_NONE;
    led = 1'b0;

    if (!alarm_active) begin
      if (since_window >= TIME_BITS'(cfg.detect_window_ms)) begin
        if (mag >= cfg.fall_threshold) begin
          alarm_active_next = 1'b1;
          screen_state_next = SCREEN_FALL;
          ev                = EV_FALL;
        end
        window_start_ms_next = t;
        flash_start_ms_next  = t;
      end
    end else begin
      if (item.button_pressed && !cancel_pending) begin
        cancel_pending_next = 1'b1;
        ev                  = EV_CANCELLED;
      end
      if (!cancel_pending_next) begin
        if (since_window <= TIME_BITS'(cfg.alarm_duration_ms)) begin
          if (since_flash >= TIME_BITS'(cfg.flash_half_period_ms)) begin
            flash_level_next    = !flash_level;
            flash_start_ms_next = t;
          end
          led = flash_level_next;
        end else begin
          window_start_ms_next = t;
          alarm_active_next    = 1'b0;
          screen_state_next    = SCREEN_OK;
          ev                   = EV_EXPIRED;
        end
      end else begin
        if (since_window <= TIME_BITS'(cfg.cancel_hold_ms)) begin
          if (!cancel_shown) begin
            cancel_shown_next = 1'b1;
            screen_state_next = SCREEN_CANCEL;
          end
        end else begin
          window_start_ms_next = t;
          cancel_shown_next    = 1'b0;
          cancel_pending_next  = 1'b0;
          alarm_active_next    = 1'b0;
          screen_state_next    = SCREEN_OK;
          ev                   = EV_CANCEL_ENDED;
        end
      end
    end

    result.led_lit      = led;
    result.display_mode = screen_state_next;
    result.event_code   = ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_active    <= 1'b0;
      cancel_pending  <= 1'b0;
      cancel_shown    <= 1'b0;
      flash_level     <= 1'b0;
      window_start_ms <= '0;
      flash_start_ms  <= '0;
      screen_state    <= SCREEN_OK;
    end else if (step) begin
      alarm_active    <= alarm_active_next;
      cancel_pending  <= cancel_pending_next;
      cancel_shown    <= cancel_shown_next;
      flash_level     <= flash_level_next;
      window_start_ms <= window_start_ms_next;
      flash_start_ms  <= flash_start_ms_next;
      screen_state    <= screen_state_next;
    end
  end

`ifndef SYNTH
  a_pending_in_alarm: assert property (@(posedge clk) disable iff (rst)
    cancel_pending |-> alarm_active)
    else $error("cancel pending outside alarm");

  a_shown_pending: assert property (@(posedge clk) disable iff (rst)
    cancel_shown |-> cancel_pending)
    else $error("cancel screen without pending cancel");

  a_ok_when_idle: assert property (@(posedge clk) disable iff (rst)
    !alarm_active |-> screen_state == SCREEN_OK)
    else $error("non-ok screen outside alarm");

  a_fall_raises: assert property (@(posedge clk) disable iff (rst)
    step && result.event_code == EV_FALL |=> alarm_active && !cancel_pending)
    else $error("fall event did not raise alarm");

  a_led_only_flashing: assert property (@(posedge clk) disable iff (rst)
    step && result.led_lit |-> alarm_active && !cancel_pending)
    else $error("led lit outside flashing alarm");
`endif

endmodule
`default_nettype wire

// File: src/fall_alarm_controller_top.sv
// The input word is registered in in_q, the core result in out_data; a stalled
// output holds the word in in_q. Throughput: one word per cycle while not stalled;
// the state update is a single pass of compares and subtractions between the
// input register and the result register.
// Reset (rst, synchronous): pipeline empty, alarm idle, ok screen, registers
// back to their defaults (4096 threshold, 500/10000/500/5000 ms).
`default_nettype none
module fall_alarm_controller_top
  import fac_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  in_item_t                       in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output out_item_t                      out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_q_valid;
  out_item_t result;
  logic      out_free;
  logic      step;

  assign cfg_ready = 1'b1;

  fac_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_free = !out_valid || out_ready;
  assign step     = in_q_valid && out_free;
  assign in_ready = !in_q_valid || out_free;

  fac_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire
